### src/round_robin_time_slice_scheduler_macros.svh
// assertion macros for the round-robin time-slice scheduler
// used by round_robin_time_slice_scheduler.sv, no other dependencies
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrts assertion failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrts assertion failed");

`endif

### src/rrts_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the round-robin time-slice scheduler
// no dependencies; used by the channel interfaces and the top level
package rrts_pkg;

   localparam int QUEUE_DEPTH   = 1024;
   localparam int PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_W         = $clog2(QUEUE_DEPTH + 2);
   localparam int JOB_W         = 10;
   localparam int QUANTUM_W     = 16;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd500;

   typedef enum logic [CMD_W-1:0] {
      CMD_ARRIVE = 2'd0,
      CMD_DONE   = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_IDLE_DONE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

### src/rrts_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the scheduler: request, response, csr write
// depends on rrts_pkg for field widths
interface rrts_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrts_pkg::CMD_W-1:0]  cmd;
   logic [rrts_pkg::JOB_W-1:0]  job_id;
   modport source (output valid, cmd, job_id, input ready);
   modport sink   (input valid, cmd, job_id, output ready);
endinterface

interface rrts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          run_valid;
   logic [rrts_pkg::JOB_W-1:0]    run_job;
   logic                          switched;
   logic [rrts_pkg::STATUS_W-1:0] status;
   modport source (output valid, run_valid, run_job, switched, status, input ready);
   modport sink   (input valid, run_valid, run_job, switched, status, output ready);
endinterface

interface rrts_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rrts_pkg::QUANTUM_W-1:0] quantum;
   modport source (output valid, quantum, input ready);
   modport sink   (input valid, quantum, output ready);
endinterface

### src/round_robin_time_slice_scheduler.sv
`timescale 1ns / 1ps
// round-robin time-slice scheduler: ready queue in a synchronous ram, registered read
// results go to the response register; a tick that pops first reads the queue head
// throughput: one transaction per cycle unless rsp stalls or a tick pops (ram read)
// reset: synchronous, clears pointers, counters, running flag; quantum returns to 500
// the queue ram is not cleared: entries are only read after being written
`include "round_robin_time_slice_scheduler_macros.svh"

module round_robin_time_slice_scheduler (
   input  logic       clock,
   input  logic       reset,
   rrts_req_if.sink   req_chan,
   rrts_rsp_if.source rsp_chan,
   rrts_csr_if.sink   csr_chan
);

   localparam int PW = rrts_pkg::PTR_W;
   localparam int CW = rrts_pkg::CNT_W;
   localparam int OW = rrts_pkg::OUT_W;
   localparam int JW = rrts_pkg::JOB_W;
   localparam int QW = rrts_pkg::QUANTUM_W;

   logic [JW-1:0] queue_mem [rrts_pkg::QUEUE_DEPTH];
   logic [JW-1:0] rd_data_ff;

   rrts_pkg::state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [OW-1:0] outstanding_ff, outstanding_in;
   logic [JW-1:0] current_ff, current_in;
   logic [QW-1:0] slice_ff, slice_in;
   logic          running_ff, running_in;
   logic          preempt_ff, preempt_in;
   logic [QW-1:0] quantum_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          run_valid_ff, run_valid_in;
   logic [JW-1:0]                 run_job_ff, run_job_in;
   logic                          switched_ff, switched_in;
   logic [rrts_pkg::STATUS_W-1:0] status_ff, status_in;

   logic          req_fire, rsp_fire, rsp_load, mem_we, rd_en, need_pop, expired, pop_idle;
   logic [JW-1:0] mem_wdata;
   logic [QW-1:0] q_eff;
   rrts_pkg::cmd_type cmd;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign cmd      = rrts_pkg::cmd_type'(req_chan.cmd);

   assign req_chan.ready = (state_ff == rrts_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.run_valid = run_valid_ff;
   assign rsp_chan.run_job   = run_job_ff;
   assign rsp_chan.switched  = switched_ff;
   assign rsp_chan.status    = status_ff;

   assign q_eff    = (quantum_ff == '0) ? QW'(1) : quantum_ff;
   assign expired  = (slice_ff >= q_eff);
   // a job left idle has a zero slice; running_ff keeps the two pops out of one tick
   assign pop_idle = !running_ff && (count_ff != '0);
   assign need_pop = pop_idle ||
                     ((outstanding_ff != '0) && running_ff && expired && (count_ff != '0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire && (cmd == rrts_pkg::CMD_TICK) && need_pop) state_in = rrts_pkg::ST_POP;
         end
         rrts_pkg::ST_POP: state_in = rrts_pkg::ST_IDLE;
         default: state_in = rrts_pkg::ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      outstanding_in = outstanding_ff;
      current_in     = current_ff;
      slice_in       = slice_ff;
      running_in     = running_ff;
      preempt_in     = preempt_ff;
      mem_we         = 1'b0;
      mem_wdata      = current_ff;
      rd_en          = 1'b0;
      rsp_load       = 1'b0;
      run_valid_in   = 1'b0;
      run_job_in     = '0;
      switched_in    = 1'b0;
      status_in      = rrts_pkg::STATUS_OK;
      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  rrts_pkg::CMD_ARRIVE: begin
                     rsp_load = 1'b1;
                     if (count_ff >= CW'(rrts_pkg::QUEUE_DEPTH)) begin
                        status_in = rrts_pkg::STATUS_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        mem_wdata      = req_chan.job_id;
                        tail_in        = rrts_pkg::ptr_next(tail_ff);
                        count_in       = count_ff + 1'b1;
                        outstanding_in = outstanding_ff + 1'b1;
                     end
                  end
                  rrts_pkg::CMD_DONE: begin
                     rsp_load = 1'b1;
                     if (!running_ff) begin
                        status_in = rrts_pkg::STATUS_IDLE_DONE;
                     end else begin
                        running_in = 1'b0;
                        slice_in   = '0;
                        if (outstanding_ff != '0) outstanding_in = outstanding_ff - 1'b1;
                     end
                  end
                  rrts_pkg::CMD_TICK: begin
                     if (need_pop) begin
                        // head read now, finished next cycle
                        rd_en      = 1'b1;
                        preempt_in = !pop_idle;
                     end else begin
                        rsp_load = 1'b1;
                        if (outstanding_ff != '0) begin
                           running_in   = 1'b1;
                           slice_in     = (expired ? '0 : slice_ff) + 1'b1;
                           run_valid_in = 1'b1;
                           run_job_in   = current_ff;
                        end
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         rrts_pkg::ST_POP: begin
            rsp_load   = 1'b1;
            head_in    = rrts_pkg::ptr_next(head_ff);
            current_in = rd_data_ff;
            if (preempt_ff) begin
               // head was read last cycle, so a full queue still loses nothing
               mem_we       = 1'b1;
               mem_wdata    = current_ff;
               tail_in      = rrts_pkg::ptr_next(tail_ff);
               slice_in     = QW'(1);
               run_valid_in = 1'b1;
               run_job_in   = rd_data_ff;
               switched_in  = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (outstanding_ff != '0) begin
                  running_in   = 1'b1;
                  slice_in     = slice_ff + 1'b1;
                  run_valid_in = 1'b1;
                  run_job_in   = rd_data_ff;
                  switched_in  = 1'b1;
               end
            end
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_fire ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rrts_pkg::ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         outstanding_ff <= '0;
         current_ff     <= '0;
         slice_ff       <= '0;
         running_ff     <= 1'b0;
         preempt_ff     <= 1'b0;
         quantum_ff     <= rrts_pkg::QUANTUM_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         outstanding_ff <= outstanding_in;
         current_ff     <= current_in;
         slice_ff       <= slice_in;
         running_ff     <= running_in;
         preempt_ff     <= preempt_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) quantum_ff <= csr_chan.quantum;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         run_valid_ff <= run_valid_in;
         run_job_ff   <= run_job_in;
         switched_ff  <= switched_in;
         status_ff    <= status_in;
      end
   end

   // ready queue ram: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[tail_ff] <= mem_wdata;
      if (rd_en) rd_data_ff <= queue_mem[head_ff];
   end

   `RRTS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(rrts_pkg::QUEUE_DEPTH))
   `RRTS_ASSERT_NOW(a_queued_counted, clock, reset, 1'b1, OW'(count_ff) <= outstanding_ff)
   `RRTS_ASSERT_NOW(a_no_accept_in_pop, clock, reset, state_ff == rrts_pkg::ST_POP, !req_chan.ready)
   `RRTS_ASSERT_NEXT(a_preempt_keeps_count, clock, reset, (state_ff == rrts_pkg::ST_POP) && preempt_ff, count_ff == $past(count_ff))
   `RRTS_ASSERT_NEXT(a_grant_runs, clock, reset, rsp_load && run_valid_in, running_ff && (current_ff == run_job_ff))

endmodule
